@@ hdl/nrgs_pkg.sv @@
// Package for the no-repeat greedy sequencer.
// Holds the transaction payload types, opcode and status codes, and the cell command struct.
// No dependencies.
package nrgs_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned COUNT_IN_W = 16;
  localparam int unsigned KIND_OUT_W = 5;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EMIT  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [COUNT_IN_W-1:0] kind_count_in;
  } in_t;

  typedef struct packed {
    logic [KIND_OUT_W-1:0] kind_out;
    logic                  is_final;
    logic [STATUS_W-1:0]   status;
  } out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic emit;
  } cell_cmd_t;

endpackage

@@ hdl/nrgs_cell.sv @@
// One entry cell of the sorted kind table.
// Holds a count, kind number and valid bit; shifts with its neighbors on insert and reposition.
// Depends on nrgs_pkg.
module nrgs_cell #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned KIND_WIDTH  = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nrgs_pkg::cell_cmd_t     cmd_i,
  input  logic [COUNT_WIDTH-1:0]  bcast_count_i,
  input  logic [KIND_WIDTH-1:0]   bcast_kind_i,
  input  logic                    is_pick_i,
  input  logic                    after_pick_i,
  input  logic [COUNT_WIDTH-1:0]  left_count_i,
  input  logic [KIND_WIDTH-1:0]   left_kind_i,
  input  logic                    left_valid_i,
  input  logic                    left_flag_i,
  input  logic [COUNT_WIDTH-1:0]  right_count_i,
  input  logic [KIND_WIDTH-1:0]   right_kind_i,
  input  logic                    right_valid_i,
  input  logic                    right_flag_i,
  output logic [COUNT_WIDTH-1:0]  count_o,
  output logic [KIND_WIDTH-1:0]   kind_o,
  output logic                    valid_o,
  output logic                    flag_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [KIND_WIDTH-1:0]  kind_q, kind_d;
  logic                   valid_q, valid_d;
  logic                   flag;

  // load: entry sorts after the new count; emit: entry is in the run equal to the picked count
  always_comb begin
    flag = 1'b0;
    if (cmd_i.load) begin
      flag = !valid_q || (count_q < bcast_count_i);
    end else if (cmd_i.emit) begin
      flag = after_pick_i && valid_q && (count_q == bcast_count_i);
    end
  end

  always_comb begin
    count_d = count_q;
    kind_d  = kind_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      count_d = '0;
      kind_d  = '0;
      valid_d = 1'b0;
    end else if (cmd_i.load) begin
      if (left_flag_i) begin
        count_d = left_count_i;
        kind_d  = left_kind_i;
        valid_d = left_valid_i;
      end else if (flag) begin
        count_d = bcast_count_i;
        kind_d  = bcast_kind_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.emit) begin
      if (is_pick_i || flag) begin
        if (right_flag_i) begin
          count_d = right_count_i;
          kind_d  = right_kind_i;
          valid_d = right_valid_i;
        end else begin
          count_d = bcast_count_i - 1'b1;
          kind_d  = bcast_kind_i;
          valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kind_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      kind_q  <= kind_d;
      valid_q <= valid_d;
    end
  end

  assign count_o = count_q;
  assign kind_o  = kind_q;
  assign valid_o = valid_q;
  assign flag_o  = flag;

endmodule

@@ hdl/no_repeat_greedy_sequencer_core.sv @@
// Top level of the no-repeat greedy sequencer.
// Instantiates a chain of nrgs_cell entries and a registered result stage.
// Depends on nrgs_pkg and nrgs_cell.
//
// The block keeps up to MAX_KINDS kind counts in a row of cells sorted by descending
// count, ties in load order. A load inserts the new kind at its sorted place, the cells
// behind it shifting one step; an emit takes the first kind that differs from the last
// emitted one, decrements it, and moves it behind the run of equal counts, the cells in
// that run shifting one step forward. Every cell compares itself against a broadcast
// count in parallel, so one transaction per cycle is accepted, and its result appears
// in the output register in the next cycle. The input stalls only while that register
// holds a result the consumer has not taken.
module no_repeat_greedy_sequencer_core #(
  parameter int unsigned MAX_KINDS   = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nrgs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nrgs_pkg::out_t out_data_o
);

  localparam int unsigned KindWidth = $clog2(MAX_KINDS + 1);

  logic [COUNT_WIDTH-1:0] cell_count [MAX_KINDS];
  logic [KindWidth-1:0]   cell_kind  [MAX_KINDS];
  logic                   cell_valid [MAX_KINDS];
  logic                   cell_flag  [MAX_KINDS];

  logic [KindWidth-1:0]   kinds_loaded_q, kinds_loaded_d;
  logic [KindWidth-1:0]   last_kind_q, last_kind_d;
  logic                   out_valid_q, out_valid_d;
  nrgs_pkg::out_t         out_data_q, out_data_d;

  logic                   in_fire;
  logic                   full;
  logic                   nonempty;
  logic                   pick1;
  logic [COUNT_WIDTH-1:0] pick_count;
  logic [KindWidth-1:0]   pick_kind;
  logic [COUNT_WIDTH-1:0] load_count;
  logic [COUNT_WIDTH-1:0] bcast_count;
  logic [KindWidth-1:0]   bcast_kind;
  logic [31:0]            kind_ext;
  logic                   is_final;
  nrgs_pkg::cell_cmd_t    cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign full       = (kinds_loaded_q == KindWidth'(MAX_KINDS));
  assign nonempty   = (cell_count[0] != '0);
  assign pick1      = (cell_kind[0] == last_kind_q) && cell_valid[1] && (cell_count[1] != '0);
  assign pick_count = pick1 ? cell_count[1] : cell_count[0];
  assign pick_kind  = pick1 ? cell_kind[1] : cell_kind[0];
  assign load_count = COUNT_WIDTH'(in_data_i.kind_count_in);
  assign is_final   = !pick1 && (pick_count == COUNT_WIDTH'(1)) && (cell_count[1] == '0);
  assign kind_ext   = 32'(pick_kind);

  always_comb begin
    cmd       = '0;
    cmd.clear = in_fire && (in_data_i.opcode == nrgs_pkg::OP_CLEAR);
    cmd.load  = in_fire && (in_data_i.opcode == nrgs_pkg::OP_LOAD) && !full;
    cmd.emit  = in_fire && (in_data_i.opcode == nrgs_pkg::OP_EMIT) && nonempty;
  end

  assign bcast_count = cmd.emit ? pick_count : load_count;
  assign bcast_kind  = cmd.emit ? pick_kind : KindWidth'(kinds_loaded_q + 1'b1);

  for (genvar i = 0; i < MAX_KINDS; i++) begin : g_cell
    logic [COUNT_WIDTH-1:0] l_count, r_count;
    logic [KindWidth-1:0]   l_kind, r_kind;
    logic                   l_valid, r_valid, l_flag, r_flag;
    logic                   is_pick, after_pick;

    if (i == 0) begin : g_left_edge
      assign l_count = '0;
      assign l_kind  = '0;
      assign l_valid = 1'b0;
      assign l_flag  = 1'b0;
    end else begin : g_left
      assign l_count = cell_count[i-1];
      assign l_kind  = cell_kind[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_flag  = cell_flag[i-1];
    end

    if (i == MAX_KINDS - 1) begin : g_right_edge
      assign r_count = '0;
      assign r_kind  = '0;
      assign r_valid = 1'b0;
      assign r_flag  = 1'b0;
    end else begin : g_right
      assign r_count = cell_count[i+1];
      assign r_kind  = cell_kind[i+1];
      assign r_valid = cell_valid[i+1];
      assign r_flag  = cell_flag[i+1];
    end

    if (i == 0) begin : g_sel0
      assign is_pick    = !pick1;
      assign after_pick = 1'b0;
    end else if (i == 1) begin : g_sel1
      assign is_pick    = pick1;
      assign after_pick = !pick1;
    end else begin : g_seln
      assign is_pick    = 1'b0;
      assign after_pick = 1'b1;
    end

    nrgs_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .KIND_WIDTH (KindWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .bcast_count_i(bcast_count),
      .bcast_kind_i (bcast_kind),
      .is_pick_i    (is_pick),
      .after_pick_i (after_pick),
      .left_count_i (l_count),
      .left_kind_i  (l_kind),
      .left_valid_i (l_valid),
      .left_flag_i  (l_flag),
      .right_count_i(r_count),
      .right_kind_i (r_kind),
      .right_valid_i(r_valid),
      .right_flag_i (r_flag),
      .count_o      (cell_count[i]),
      .kind_o       (cell_kind[i]),
      .valid_o      (cell_valid[i]),
      .flag_o       (cell_flag[i])
    );
  end

  always_comb begin
    kinds_loaded_d = kinds_loaded_q;
    last_kind_d    = last_kind_q;
    if (cmd.clear) begin
      kinds_loaded_d = '0;
      last_kind_d    = '0;
    end else if (cmd.load) begin
      kinds_loaded_d = KindWidth'(kinds_loaded_q + 1'b1);
    end else if (cmd.emit) begin
      last_kind_d = pick_kind;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      case (in_data_i.opcode)
        nrgs_pkg::OP_LOAD: begin
          if (full) begin
            out_data_d.status = nrgs_pkg::ST_FULL;
          end
        end
        nrgs_pkg::OP_EMIT: begin
          if (nonempty) begin
            out_data_d.kind_out = kind_ext[nrgs_pkg::KIND_OUT_W-1:0];
            out_data_d.is_final = is_final;
          end else begin
            out_data_d.status = nrgs_pkg::ST_EMPTY;
          end
        end
        default: begin
          out_data_d = '0;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_loaded_q <= '0;
      last_kind_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      kinds_loaded_q <= kinds_loaded_d;
      last_kind_q    <= last_kind_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ bench/no_repeat_greedy_sequencer_core_tb.sv @@
// Self-checking testbench for no_repeat_greedy_sequencer_core: directed and random
// transactions with random idling on both sides, checked against an in-bench predictor.
// Depends on nrgs_pkg and the RTL of no_repeat_greedy_sequencer_core.
module no_repeat_greedy_sequencer_core_tb;

  localparam int unsigned MAX_K = 16;
  localparam int unsigned RANDOM_ITEMS = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  nrgs_pkg::in_t in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  nrgs_pkg::out_t out_data;

  no_repeat_greedy_sequencer_core #(
    .MAX_KINDS(MAX_K),
    .COUNT_WIDTH(16)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  always #10 clk = ~clk;

  // predictor state: table sorted by descending count, ties in load order
  logic [15:0] slot_count [MAX_K];
  logic [4:0] slot_kind [MAX_K];
  int unsigned kinds_loaded;
  logic [4:0] last_kind;
  int unsigned items_left;

  nrgs_pkg::in_t pending_requests[$];
  nrgs_pkg::out_t predicted_outcomes[$];
  int unsigned queued_items = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  bit in_taken = 1'b0;
  int unsigned idle_left = 0;
  int unsigned calm_left = 0;
  int unsigned stall_left = 0;
  bit hold_done = 1'b0;

  function automatic void clear_table();
    for (int i = 0; i < MAX_K; i++) begin
      slot_count[i] = '0;
      slot_kind[i] = '0;
    end
    kinds_loaded = 0;
    last_kind = '0;
    items_left = 0;
  endfunction

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [15:0] c;
    logic [4:0] k;
    c = slot_count[a];
    k = slot_kind[a];
    slot_count[a] = slot_count[b];
    slot_kind[a] = slot_kind[b];
    slot_count[b] = c;
    slot_kind[b] = k;
  endfunction

  function automatic nrgs_pkg::out_t next_outcome(input nrgs_pkg::in_t req);
    nrgs_pkg::out_t res;
    int unsigned p;
    int unsigned n;
    int unsigned pick;
    int unsigned any;
    int unsigned i;
    bit found;
    logic [4:0] new_kind;
    res = '0;
    n = kinds_loaded;
    case (req.opcode)
      nrgs_pkg::OP_CLEAR: clear_table();
      nrgs_pkg::OP_LOAD: begin
        if (kinds_loaded >= MAX_K) begin
          res.status = nrgs_pkg::ST_FULL;
        end else begin
          p = kinds_loaded;
          new_kind = 5'(kinds_loaded + 1);
          slot_count[p] = req.kind_count_in;
          slot_kind[p] = new_kind;
          items_left = items_left + req.kind_count_in;
          kinds_loaded = kinds_loaded + 1;
          while (p > 0 && slot_count[p-1] < slot_count[p]) begin
            swap_slots(p - 1, p);
            p = p - 1;
          end
        end
      end
      nrgs_pkg::OP_EMIT: begin
        if (items_left == 0) begin
          res.status = nrgs_pkg::ST_EMPTY;
        end else begin
          pick = n;
          any = n;
          found = 1'b0;
          for (i = 0; i < n; i++) begin
            if (!found && slot_count[i] != 0) begin
              if (any == n) any = i;
              if (slot_kind[i] != last_kind) begin
                pick = i;
                found = 1'b1;
              end
            end
          end
          if (!found) pick = any;
          slot_count[pick] = slot_count[pick] - 1'b1;
          items_left = items_left - 1;
          last_kind = slot_kind[pick];
          res.kind_out = last_kind;
          res.is_final = (items_left == 0);
          while (pick + 1 < n && slot_count[pick] < slot_count[pick+1]) begin
            swap_slots(pick, pick + 1);
            pick = pick + 1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_item(input logic [nrgs_pkg::OPCODE_W-1:0] op,
                                   input int unsigned cnt);
    nrgs_pkg::in_t req;
    req.opcode = op;
    req.kind_count_in = cnt[nrgs_pkg::COUNT_IN_W-1:0];
    pending_requests = {pending_requests, req};
    if (op != nrgs_pkg::OP_NOP) queued_items = queued_items + 1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_requests.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
        idle_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!hold_done && accepted_count >= 400) begin
      hold_done <= 1'b1;
      out_stall <= 1'b1;
      stall_left <= 250;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_stall();
    end
  end

  // monitor: check the result first, then record the accepted transaction
  always @(posedge clk) begin
    nrgs_pkg::out_t want;
    nrgs_pkg::out_t expect_res;
    in_taken = in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d final %0d status %0d",
                   $time, out_data.kind_out, out_data.is_final, out_data.status);
          fail_count = fail_count + 1;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("kind_out", want.kind_out, out_data.kind_out);
          check_field("is_final", want.is_final, out_data.is_final);
          check_field("status", want.status, out_data.status);
        end
      end
      if (in_taken) begin
        expect_res = next_outcome(in_data);
        predicted_outcomes = {predicted_outcomes, expect_res};
        accepted_count = accepted_count + 1;
      end
    end
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned nk;
    int unsigned total;
    int unsigned c;
    int unsigned target;
    clear_table();

    // directed: empty emit, no-ops, widest count, lone kind repeating, zero count and ties
    add_item(nrgs_pkg::OP_CLEAR, 16'hFFFF);
    add_item(nrgs_pkg::OP_EMIT, 0);
    add_item(nrgs_pkg::OP_NOP, 16'hFFFF);
    add_item(nrgs_pkg::OP_LOAD, 16'hFFFF);
    add_item(nrgs_pkg::OP_CLEAR, 0);
    add_item(nrgs_pkg::OP_LOAD, 3);
    repeat (4) add_item(nrgs_pkg::OP_EMIT, 16'hFFFF);
    add_item(nrgs_pkg::OP_CLEAR, 0);
    add_item(nrgs_pkg::OP_LOAD, 0);
    add_item(nrgs_pkg::OP_LOAD, 2);
    add_item(nrgs_pkg::OP_LOAD, 2);
    add_item(nrgs_pkg::OP_LOAD, 1);
    repeat (6) add_item(nrgs_pkg::OP_EMIT, 0);

    target = queued_items + RANDOM_ITEMS;
    while (queued_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if ($urandom_range(0, 9) != 0)
          add_item(nrgs_pkg::OP_CLEAR, $urandom_range(0, 16'hFFFF));
        nk = $urandom_range(1, MAX_K);
        total = 0;
        repeat (nk) begin
          c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
          total = total + c;
          add_item(nrgs_pkg::OP_LOAD, c);
        end
        repeat (total + $urandom_range(0, 2))
          add_item(nrgs_pkg::OP_EMIT, $urandom_range(0, 16'hFFFF));
      end else if (r < 75) begin
        // overfill the table
        add_item(nrgs_pkg::OP_CLEAR, 0);
        total = 0;
        repeat (MAX_K + $urandom_range(1, 3)) begin
          c = $urandom_range(0, 2);
          total = total + c;
          add_item(nrgs_pkg::OP_LOAD, c);
        end
        repeat (total + 1) add_item(nrgs_pkg::OP_EMIT, 0);
      end else if (r < 88) begin
        repeat ($urandom_range(4, 20)) begin
          c = $urandom_range(0, 19);
          if (c == 0) add_item(nrgs_pkg::OP_CLEAR, 0);
          else if (c < 8) add_item(nrgs_pkg::OP_LOAD, $urandom_range(0, 4));
          else add_item(nrgs_pkg::OP_EMIT, 0);
        end
      end else begin
        repeat ($urandom_range(1, 8))
          add_item(2'($urandom_range(0, 3)), $urandom_range(0, 16'hFFFF));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_requests.size() > 0 || in_valid || predicted_outcomes.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
